// File: rtl/aabb_pkg.sv
// ---------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the bounding box collision pipeline.
// ---------------------------------------------------------------------------
package aabb_pkg;

    localparam int CRD_W  = 32;
    localparam int SIZE_W = 31;
    localparam int SCL_W  = 16;
    localparam int RAD_W  = 31;
    localparam int HALF_W = 38;
    localparam int EXT_W  = 40;
    localparam int PROD_W = SIZE_W + SCL_W;
    localparam int HALF_SHIFT = 9;
    localparam int DIFF_W = CRD_W + 1;
    localparam int SQ_W   = 2 * RAD_W;
    localparam int SUM_W  = 64;
    localparam int NUM_STAGES = 7;

    localparam int IDX_W  = 3;
    localparam int CFGD_W = 48;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIZE_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIZE_Z   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SCALE    = 3'd6;

    localparam logic [SIZE_W-1:0] SIZE_RST  = 31'd65536;
    localparam logic [SCL_W-1:0]  SCALE_RST = 16'd256;

    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_BOX    = 2'd1,
        OP_SPHERE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [2:0][CRD_W-1:0]  center;
        logic [2:0][SIZE_W-1:0] size;
        logic [2:0][SCL_W-1:0]  scale;
    } t_cfg;

    typedef struct packed {
        t_op                   op;
        logic [2:0][CRD_W-1:0] pnt;
        logic [2:0][CRD_W-1:0] omin;
        logic [2:0][CRD_W-1:0] omax;
        logic [RAD_W-1:0]      radius;
    } t_req;

    typedef struct packed {
        t_op                   op;
        logic [2:0][CRD_W-1:0] pnt;
        logic [2:0][CRD_W-1:0] cl;
        logic                  pt_hit;
        logic                  bx_hit;
        logic [RAD_W-1:0]      radius;
    } t_geom;

endpackage

// File: rtl/aabb_cfg.sv
// ---------------------------------------------------------------------------
// aabb_cfg
// Configuration registers for the box center, size and per-axis scale.
// ---------------------------------------------------------------------------
module aabb_cfg
    import aabb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFGD_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center <= '0;
            r_cfg.size   <= {SIZE_RST, SIZE_RST, SIZE_RST};
            r_cfg.scale  <= {SCALE_RST, SCALE_RST, SCALE_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X: r_cfg.center[0] <= i_cfg_data[CRD_W-1:0];
                REG_CENTER_Y: r_cfg.center[1] <= i_cfg_data[CRD_W-1:0];
                REG_CENTER_Z: r_cfg.center[2] <= i_cfg_data[CRD_W-1:0];
                REG_SIZE_X:   r_cfg.size[0]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   r_cfg.size[1]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:   r_cfg.size[2]   <= i_cfg_data[SIZE_W-1:0];
                REG_SCALE:    r_cfg.scale     <= i_cfg_data[3*SCL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/aabb_geom.sv
// ---------------------------------------------------------------------------
// aabb_geom
// Stages one to three: half extents, box corners, containment, overlap
// and clamping of the query point into the box.
// ---------------------------------------------------------------------------
module aabb_geom
    import aabb_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_cfg       i_cfg,
    input  t_req       i_req,
    output t_geom      o_geom
);

    t_req                   r_s1_req;
    logic [2:0][HALF_W-1:0] r_s1_half;
    logic [2:0][HALF_W-1:0] n_s1_half;

    t_req                   r_s2_req;
    logic [2:0][EXT_W-1:0]  r_s2_mn;
    logic [2:0][EXT_W-1:0]  r_s2_mx;
    logic [2:0][EXT_W-1:0]  n_s2_mn;
    logic [2:0][EXT_W-1:0]  n_s2_mx;

    t_geom r_s3;
    t_geom n_s3;

    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int a = 0; a < 3; a++) begin
            prod = PROD_W'(i_cfg.size[a]) * PROD_W'(i_cfg.scale[a]);
            n_s1_half[a] = prod[HALF_SHIFT +: HALF_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_req  <= i_req;
            r_s1_half <= n_s1_half;
        end
    end

    always_comb begin
        logic signed [EXT_W-1:0] c;
        logic signed [EXT_W-1:0] h;
        for (int a = 0; a < 3; a++) begin
            c = EXT_W'($signed(i_cfg.center[a]));
            h = $signed({{(EXT_W-HALF_W){1'b0}}, r_s1_half[a]});
            n_s2_mn[a] = c - h;
            n_s2_mx[a] = c + h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_req <= r_s1_req;
            r_s2_mn  <= n_s2_mn;
            r_s2_mx  <= n_s2_mx;
        end
    end

    always_comb begin
        logic signed [EXT_W-1:0] p;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] omn;
        logic signed [EXT_W-1:0] omx;
        logic signed [EXT_W-1:0] c;
        n_s3.op     = r_s2_req.op;
        n_s3.pnt    = r_s2_req.pnt;
        n_s3.radius = r_s2_req.radius;
        n_s3.pt_hit = 1'b1;
        n_s3.bx_hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            p   = EXT_W'($signed(r_s2_req.pnt[a]));
            omn = EXT_W'($signed(r_s2_req.omin[a]));
            omx = EXT_W'($signed(r_s2_req.omax[a]));
            lo  = $signed(r_s2_mn[a]);
            hi  = $signed(r_s2_mx[a]);
            if (p < lo || p > hi) begin
                n_s3.pt_hit = 1'b0;
            end
            if (!(hi > omn && omx > lo)) begin
                n_s3.bx_hit = 1'b0;
            end
            if (p < lo) begin
                c = lo;
            end else if (p > hi) begin
                c = hi;
            end else begin
                c = p;
            end
            n_s3.cl[a] = c[CRD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_geom = r_s3;

endmodule

// File: rtl/aabb_sphere.sv
// ---------------------------------------------------------------------------
// aabb_sphere
// Stages four to seven: axis distances, squares, sum of squares and the
// final result selection into the output register.
// ---------------------------------------------------------------------------
module aabb_sphere
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic [3:0]            i_en,
    input  t_geom                 i_geom,
    output logic                  o_hit,
    output logic [2:0][CRD_W-1:0] o_closest
);

    t_op                    r_s4_op;
    logic [2:0][CRD_W-1:0]  r_s4_cl;
    logic                   r_s4_pt;
    logic                   r_s4_bx;
    logic                   r_s4_far;
    logic [2:0][RAD_W-1:0]  r_s4_m;
    logic [RAD_W-1:0]       r_s4_rad;
    logic                   n_s4_far;
    logic [2:0][RAD_W-1:0]  n_s4_m;

    t_op                    r_s5_op;
    logic [2:0][CRD_W-1:0]  r_s5_cl;
    logic                   r_s5_pt;
    logic                   r_s5_bx;
    logic                   r_s5_far;
    logic [2:0][SQ_W-1:0]   r_s5_sq;
    logic [SQ_W-1:0]        r_s5_rr;

    t_op                    r_s6_op;
    logic [2:0][CRD_W-1:0]  r_s6_cl;
    logic                   r_s6_pt;
    logic                   r_s6_bx;
    logic                   r_s6_far;
    logic [SUM_W-1:0]       r_s6_sum;
    logic [SQ_W-1:0]        r_s6_rr;

    logic                   r_hit;
    logic [2:0][CRD_W-1:0]  r_closest;
    logic                   n_hit;
    logic [2:0][CRD_W-1:0]  n_closest;

    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        mag;
        n_s4_far = 1'b0;
        for (int a = 0; a < 3; a++) begin
            d   = DIFF_W'($signed(i_geom.pnt[a])) - DIFF_W'($signed(i_geom.cl[a]));
            mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            if (mag[DIFF_W-1] || mag[DIFF_W-2]) begin
                n_s4_far = 1'b1;
            end
            n_s4_m[a] = mag[RAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4_op  <= i_geom.op;
            r_s4_cl  <= i_geom.cl;
            r_s4_pt  <= i_geom.pt_hit;
            r_s4_bx  <= i_geom.bx_hit;
            r_s4_far <= n_s4_far;
            r_s4_m   <= n_s4_m;
            r_s4_rad <= i_geom.radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s5_op  <= r_s4_op;
            r_s5_cl  <= r_s4_cl;
            r_s5_pt  <= r_s4_pt;
            r_s5_bx  <= r_s4_bx;
            r_s5_far <= r_s4_far;
            for (int a = 0; a < 3; a++) begin
                r_s5_sq[a] <= SQ_W'(r_s4_m[a]) * SQ_W'(r_s4_m[a]);
            end
            r_s5_rr  <= SQ_W'(r_s4_rad) * SQ_W'(r_s4_rad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s6_op  <= r_s5_op;
            r_s6_cl  <= r_s5_cl;
            r_s6_pt  <= r_s5_pt;
            r_s6_bx  <= r_s5_bx;
            r_s6_far <= r_s5_far;
            r_s6_sum <= SUM_W'(r_s5_sq[0]) + SUM_W'(r_s5_sq[1]) + SUM_W'(r_s5_sq[2]);
            r_s6_rr  <= r_s5_rr;
        end
    end

    always_comb begin
        n_closest = r_s6_cl;
        case (r_s6_op)
            OP_POINT:  n_hit = r_s6_pt;
            OP_BOX: begin
                n_hit     = r_s6_bx;
                n_closest = '0;
            end
            OP_SPHERE: n_hit = !r_s6_far && (r_s6_sum <= SUM_W'(r_s6_rr));
            default: begin
                n_hit     = 1'b0;
                n_closest = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_hit     <= n_hit;
            r_closest <= n_closest;
        end
    end

    assign o_hit     = r_hit;
    assign o_closest = r_closest;

endmodule

// File: rtl/aabb_collision_test.sv
// ---------------------------------------------------------------------------
// aabb_collision_test
// Point, box and sphere collision tests against one configured
// axis-aligned box in Q16.16 fixed point.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         i_s_axis_tvalid/tready     tdata: query, tuser: test
// m_axis    out        o_m_axis_tvalid/tready     tdata: hit, closest point
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Seven register stages lie between a request entering and its result leaving.
// One request is taken every cycle unless every stage is full and the
// output is stalled; the multiplier and 64-bit adder stages are fully pipelined.
// Each stage holds a valid bit and stalls only when the stage after it is
// full, so bubbles close up under output backpressure.
// Reset clears all valid bits and restores the configuration defaults.
// ---------------------------------------------------------------------------
module aabb_collision_test
    import aabb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // point_x, point_y, point_z, other_min_x/y/z, other_max_x/y/z, radius, pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // hit, closest_x, closest_y, closest_z, pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFGD_W-1:0]     i_cfg_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_rdy;
    t_cfg                  cfg;
    t_req                  req;
    t_geom                 geom;
    logic                  hit;
    logic [2:0][CRD_W-1:0] closest;

    always_comb begin
        n_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        req.op = t_op'(i_s_axis_tuser);
        for (int a = 0; a < 3; a++) begin
            req.pnt[a]  = i_s_axis_tdata[a*CRD_W +: CRD_W];
            req.omin[a] = i_s_axis_tdata[(3+a)*CRD_W +: CRD_W];
            req.omax[a] = i_s_axis_tdata[(6+a)*CRD_W +: CRD_W];
        end
        req.radius = i_s_axis_tdata[9*CRD_W +: RAD_W];
    end

    aabb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    aabb_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (n_rdy[2:0]),
        .i_cfg  (cfg),
        .i_req  (req),
        .o_geom (geom)
    );

    aabb_sphere u_sphere (
        .i_clk     (i_clk),
        .i_en      (n_rdy[6:3]),
        .i_geom    (geom),
        .o_hit     (hit),
        .o_closest (closest)
    );

    assign o_s_axis_tready = n_rdy[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = {7'd0, closest[2], closest[1], closest[0], hit};

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld))
        else $error("input blocked while the pipeline has a bubble");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && !i_m_axis_tready) |=> r_vld[NUM_STAGES-1])
        else $error("stalled result was dropped");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !n_rdy[6]) |=> r_vld[5] && r_vld[6])
        else $error("stalled stage lost its request");

endmodule

// File: sim/tb_aabb_collision_test.sv
// ---------------------------------------------------------------------------
// tb_aabb_collision_test
// Self-checking testbench for the bounding box collision pipeline. A
// scoreboard computes the expected hit flag and closest point for every
// accepted request from its own copy of the box registers. Directed requests
// cover the inclusive, strict and touching boundaries and the extreme
// register settings. Several random phases follow, each with a new box,
// and both stream sides stall at random in all but the fourth phase.
// ---------------------------------------------------------------------------
module tb_aabb_collision_test
    import aabb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RAD_LSB    = 9 * CRD_W;
    localparam int PHASES     = 6;
    localparam int PHASE_REQS = 172;
    localparam int WATCHDOG   = 2000;

    typedef enum int {
        BOX_TYPICAL,
        BOX_MAX,
        BOX_MIN,
        BOX_RANDOM
    } t_box_kind;

    typedef struct packed {
        logic                  hit;
        logic [2:0][CRD_W-1:0] cl;
    } t_contact;

    class contact_scoreboard;
        logic signed [CRD_W-1:0] center [3];
        logic [SIZE_W-1:0]       size [3];
        logic [3*SCL_W-1:0]      scale;
        t_contact                pending_contacts [$];
        int                      errors;

        function new();
            for (int a = 0; a < 3; a++) begin
                center[a] = '0;
                size[a]   = SIZE_RST;
            end
            scale  = {SCALE_RST, SCALE_RST, SCALE_RST};
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFGD_W-1:0] data);
            case (idx)
                REG_CENTER_X: center[0] = data[CRD_W-1:0];
                REG_CENTER_Y: center[1] = data[CRD_W-1:0];
                REG_CENTER_Z: center[2] = data[CRD_W-1:0];
                REG_SIZE_X:   size[0]   = data[SIZE_W-1:0];
                REG_SIZE_Y:   size[1]   = data[SIZE_W-1:0];
                REG_SIZE_Z:   size[2]   = data[SIZE_W-1:0];
                REG_SCALE:    scale     = data;
                default: ;
            endcase
        endfunction

        function longint half_extent(int a);
            logic [63:0] prod;
            prod = 64'(size[a]) * 64'(scale[SCL_W*a +: SCL_W]);
            return longint'(prod >> HALF_SHIFT);
        endfunction

        function t_contact predict_contact(t_op op, logic [IN_DATA_W-1:0] q);
            t_contact    res;
            longint      c, h, lo, hi, p, omn, omx, cl, d;
            logic [63:0] m, sum, rad;
            logic        far;
            res.hit = (op != OP_NONE);
            res.cl  = '0;
            far     = 1'b0;
            sum     = '0;
            rad     = 64'(q[RAD_LSB +: RAD_W]);
            for (int a = 0; a < 3; a++) begin
                c   = longint'(center[a]);
                h   = half_extent(a);
                lo  = c - h;
                hi  = c + h;
                p   = longint'($signed(q[CRD_W*a +: CRD_W]));
                omn = longint'($signed(q[CRD_W*(3+a) +: CRD_W]));
                omx = longint'($signed(q[CRD_W*(6+a) +: CRD_W]));
                cl  = (p < lo) ? lo : ((p > hi) ? hi : p);
                case (op)
                    OP_POINT: begin
                        if (p < lo || p > hi) res.hit = 1'b0;
                        res.cl[a] = cl[CRD_W-1:0];
                    end
                    OP_BOX: begin
                        if (!(hi > omn && omx > lo)) res.hit = 1'b0;
                    end
                    OP_SPHERE: begin
                        d = p - cl;
                        m = (d < 0) ? 64'(-d) : 64'(d);
                        if (m >= 64'h8000_0000) far = 1'b1;
                        else sum += m * m;
                        res.cl[a] = cl[CRD_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (op == OP_SPHERE) res.hit = !far && (sum <= rad * rad);
            return res;
        endfunction

        function void note_query(t_op op, logic [IN_DATA_W-1:0] q);
            pending_contacts.push_back(predict_contact(op, q));
        endfunction

        function void check_contact(logic [OUT_DATA_W-1:0] d);
            t_contact want;
            if (pending_contacts.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, d);
                errors++;
                return;
            end
            want = pending_contacts.pop_front();
            if (d[0] !== want.hit) begin
                $display("%0t: hit expected %0d, actual %0d", $time, want.hit, d[0]);
                errors++;
            end
            for (int a = 0; a < 3; a++) begin
                if (d[1+CRD_W*a +: CRD_W] !== want.cl[a]) begin
                    $display("%0t: closest[%0d] expected %h, actual %h",
                             $time, a, want.cl[a], d[1+CRD_W*a +: CRD_W]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = OP_POINT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_idx = REG_CENTER_X;
    logic [CFGD_W-1:0]     cfg_data = '0;
    logic                  calm = 1'b0;
    int                    stalled_cycles = 0;

    contact_scoreboard sb = new();

    aabb_collision_test i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 28);
        if (i_rst_n && m_tvalid && m_tready) sb.check_contact(m_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [2:0][CRD_W-1:0] vec3(logic [CRD_W-1:0] x, y, z);
        return {z, y, x};
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_query(logic [2:0][CRD_W-1:0] pnt,
                                                        logic [2:0][CRD_W-1:0] omn,
                                                        logic [2:0][CRD_W-1:0] omx,
                                                        logic [RAD_W-1:0] rad);
        return {1'b0, rad, omx, omn, pnt};
    endfunction

    // Coordinates land near a face of the box, spread around it, or anywhere.
    function automatic logic [CRD_W-1:0] rand_coord(int a);
        longint c, h, span, v;
        c    = longint'(sb.center[a]);
        h    = sb.half_extent(a);
        span = 2 * h + 16;
        case ($urandom_range(3))
            0: v = c - h + longint'($urandom_range(8)) - 4;
            1: v = c + h + longint'($urandom_range(8)) - 4;
            2: v = c - span + longint'({$urandom, $urandom} % 64'(2 * span + 1));
            default: v = longint'($signed($urandom));
        endcase
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return v[CRD_W-1:0];
    endfunction

    task automatic send_query(input t_op op, input logic [IN_DATA_W-1:0] q);
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_query(op, q);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_contacts.size() > 0) @(posedge i_clk);
    endtask

    task automatic load_box(input logic [CFGD_W-1:0] vals [8]);
        for (int i = 0; i <= int'(REG_UNUSED); i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= IDX_W'(i);
            cfg_data <= vals[i];
            sb.set_reg(IDX_W'(i), vals[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFGD_W-1:0]    vals [8];
        logic [IN_DATA_W-1:0] q;
        t_op                  op;
        t_box_kind            kind;
        int                   sel;
        logic [RAD_W-1:0]     rad;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset box spans -0.5 to 0.5 on every axis.
        send_query(OP_POINT, pack_query(vec3(0, 0, 0), '0, '0, '0));
        send_query(OP_POINT, pack_query(vec3(32'h8000, 32'h8000, 32'h8000), '0, '0, '0));
        send_query(OP_POINT, pack_query(vec3(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000),
                                        '0, '0, '0));
        send_query(OP_POINT, pack_query(vec3(32'h8000, 32'h8000, 32'h8001), '0, '0, '0));
        send_query(OP_BOX, pack_query('0, vec3(32'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                      vec3(32'd100000, 1, 1), '0));
        send_query(OP_BOX, pack_query('0, vec3(32'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                      vec3(32'd100000, 1, 1), '0));
        send_query(OP_BOX, pack_query('0, vec3(10, 10, 10),
                                      vec3(32'hFFFF_FFF6, 32'hFFFF_FFF6, 32'hFFFF_FFF6), '0));
        send_query(OP_SPHERE, pack_query(vec3(32'd100000, 0, 0), '0, '0, 31'd67232));
        send_query(OP_SPHERE, pack_query(vec3(32'd100000, 0, 0), '0, '0, 31'd67231));
        send_query(OP_SPHERE, pack_query(vec3(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
                                         '0, '0, 31'h7FFF_FFFF));
        send_query(OP_SPHERE, pack_query(vec3(5, 5, 5), '0, '0, '0));
        send_query(OP_NONE, pack_query('1, '1, '1, '1));
        send_query(OP_POINT, pack_query('1, '1, '1, '1));

        drain();
        vals = '{48'h7FFF_FFFF, 48'h8000_0000, 48'h0, 48'h0, 48'h7FFF_FFFF,
                 48'h7FFF_FFFF, 48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_FFFF};
        load_box(vals);
        send_query(OP_SPHERE, pack_query(vec3(32'h8000_0000, 0, 0), '0, '0, 31'h7FFF_FFFF));
        send_query(OP_POINT, pack_query(vec3(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
                                        '0, '0, '0));
        send_query(OP_POINT, pack_query(vec3(32'h7FFF_FFFE, 0, 0), '0, '0, '0));
        send_query(OP_BOX, pack_query('0, vec3(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                                      vec3(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), '0));
        send_query(OP_SPHERE, pack_query(vec3(32'h7FFF_FFFF, 0, 0), '0, '0, '0));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                2:       kind = BOX_MAX;
                4:       kind = BOX_RANDOM;
                5:       kind = BOX_MIN;
                default: kind = BOX_TYPICAL;
            endcase
            for (int i = 0; i < 8; i++) begin
                case (kind)
                    BOX_MAX:    vals[i] = (i < 3) ? 48'h7FFF_FFFF :
                                          (i < 6) ? 48'h7FFF_FFFF : 48'hFFFF_FFFF_FFFF;
                    BOX_MIN:    vals[i] = (i < 3) ? 48'h8000_0000 : 48'h0;
                    BOX_RANDOM: vals[i] = CFGD_W'({$urandom, $urandom});
                    default:    vals[i] = (i < 3) ? 48'(32'($urandom_range(2097152)) - 32'd1048576) :
                                          (i < 6) ? 48'($urandom_range(1 << 20)) :
                                          {16'($urandom_range(1023)), 16'($urandom_range(1023)),
                                           16'($urandom_range(1023))};
                endcase
            end
            drain();
            load_box(vals);
            calm = (ph == 3);
            for (int n = 0; n < PHASE_REQS; n++) begin
                sel = $urandom_range(9);
                op  = (sel < 3) ? OP_POINT : (sel < 6) ? OP_BOX : (sel < 9) ? OP_SPHERE : OP_NONE;
                case ($urandom_range(3))
                    0:       rad = RAD_W'($urandom_range(4));
                    3:       rad = RAD_W'($urandom);
                    default: rad = RAD_W'($urandom_range(1 << 22));
                endcase
                q = pack_query(vec3(rand_coord(0), rand_coord(1), rand_coord(2)),
                               vec3(rand_coord(0), rand_coord(1), rand_coord(2)),
                               vec3(rand_coord(0), rand_coord(1), rand_coord(2)), rad);
                send_query(op, q);
            end
        end
        calm = 1'b0;

        drain();
        repeat (NUM_STAGES + 3) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_contacts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
